### design/ascd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_pkg
// Shared types, format codes and sizes for the sample convert / downmix block.
// ----------------------------------------------------------------------------
package ascd_pkg;

    // Sample format codes (sample_format register)
    localparam logic [3:0] FMT_S8     = 4'd0;
    localparam logic [3:0] FMT_S16    = 4'd1;
    localparam logic [3:0] FMT_S24    = 4'd2;
    localparam logic [3:0] FMT_S32    = 4'd3;
    localparam logic [3:0] FMT_U8     = 4'd4;
    localparam logic [3:0] FMT_U16    = 4'd5;
    localparam logic [3:0] FMT_U24    = 4'd6;
    localparam logic [3:0] FMT_U32    = 4'd7;
    localparam logic [3:0] FMT_FLOAT  = 4'd8;
    localparam logic [3:0] FMT_DOUBLE = 4'd9;

    // Register indexes on the configuration port
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // Largest frame handled; the averaging divider covers divisors 4, 6 and 8
    localparam logic [3:0] MAX_CH = 4'd8;
    localparam int POS_W = $clog2(MAX_CH);

    // Twice the per-side channel sum of one frame
    localparam int ACC_W = 19;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [63:0] sample_bits;
        logic        buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_sample;
        logic        out_wide;
        logic        out_channel;
        logic        last;
    } out_item_t;

    // Converted sample as it travels from front to back
    typedef struct packed {
        logic signed [15:0] value;
        logic               wide;
        logic               buffer_end;
    } q_entry_t;

endpackage

### design/audio_sample_convert_downmix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_convert_downmix
// PCM sample format conversion with stereo downmix of interleaved frames.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Transfer carries
//  -------   ------------------   ----------------------------------------
//  in        in_valid/in_ready    one raw sample, buffer end flag
//  out       out_valid/out_ready  one converted or averaged sample
//  cfg       APB psel/penable     sample_format at 0x0, channel_count at 0x4
//
//  An input transfer is converted in the cycle it is taken and queued; the
//  back end retires one queued sample per cycle unless the output stalls or a
//  right result is held. Frames of three or more channels yield two results;
//  the right one is held, then sent. Samples pass through the queue and the
//  result register. Reset clears the queue, frame position and accumulators.
//  Either side may stall on its own; the two-entry queue absorbs the slip.
// ----------------------------------------------------------------------------
module audio_sample_convert_downmix
    import ascd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,

    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] format_reg;
    logic [3:0] count_reg;
    logic       cfg_write;

    logic       q_full;
    logic       q_push;
    q_entry_t   q_push_data;
    logic       q_pop;
    logic       q_nonempty;
    q_entry_t   q_pop_data;

    // Configuration registers: write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_S8;
            count_reg  <= 4'd1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FORMAT: format_reg <= pwdata[3:0];
                REG_COUNT:  count_reg  <= pwdata[3:0];
                default:    format_reg <= format_reg;
            endcase
        end
    end

    // Read back the register at the decoded address
    assign prdata = {28'd0, (paddr[2] == REG_COUNT) ? count_reg : format_reg};

    // Front: accept and convert
    ascd_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .sample_format (format_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // Decoupling queue
    ascd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (q_pop_data)
    );

    // Back: frame tracking, downmix and result register
    ascd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (count_reg),
        .q_nonempty    (q_nonempty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data)
    );

endmodule

### design/ascd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_front
// Accepts raw samples and converts them to 8-bit unsigned or 16-bit signed.
// ----------------------------------------------------------------------------
module ascd_front
    import ascd_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    input  logic [3:0] sample_format,
    input  logic       q_full,
    output logic       q_push,
    output q_entry_t   q_data
);

    // trunc(m * 32767 / 2^s); m * 32767 = (m << 15) - m
    function automatic logic [16:0] scale_shift(input logic [52:0] m, input logic [10:0] s);
        logic [67:0] p;
        logic [67:0] r;
        p = {m, 15'd0} - {15'd0, m};
        r = '0;
        if (s < 11'd68)
        begin
            r = p >> s[6:0];
        end
        return r[16:0];
    endfunction

    function automatic logic signed [15:0] signed_sat(input logic neg, input logic [16:0] mag);
        logic signed [15:0] res;
        if (neg)
        begin
            res = (mag >= 17'd32768) ? 16'sh8000 : 16'(-mag);
        end
        else
        begin
            res = (mag > 17'd32767) ? 16'sh7FFF : 16'(mag);
        end
        return res;
    endfunction

    function automatic logic signed [15:0] from_float(input logic [31:0] f);
        logic [7:0]         e;
        logic [22:0]        frac;
        logic signed [15:0] res;
        e    = f[30:23];
        frac = f[22:0];
        if (e == 8'hFF)
        begin
            res = (frac != '0) ? 16'sd0 : signed_sat(f[31], 17'hFFFF);
        end
        else if (e >= 8'd128)
        begin
            res = signed_sat(f[31], 17'hFFFF);
        end
        else if (e == 8'd0)
        begin
            res = signed_sat(f[31], scale_shift({30'd0, frac}, 11'd149));
        end
        else
        begin
            res = signed_sat(f[31], scale_shift({29'd0, 1'b1, frac}, 11'd150 - {3'd0, e}));
        end
        return res;
    endfunction

    function automatic logic signed [15:0] from_double(input logic [63:0] d);
        logic [10:0]        e;
        logic [51:0]        frac;
        logic signed [15:0] res;
        e    = d[62:52];
        frac = d[51:0];
        if (e == 11'h7FF)
        begin
            res = (frac != '0) ? 16'sd0 : signed_sat(d[63], 17'hFFFF);
        end
        else if (e >= 11'd1024)
        begin
            res = signed_sat(d[63], 17'hFFFF);
        end
        else if (e == 11'd0)
        begin
            res = signed_sat(d[63], scale_shift({1'b0, frac}, 11'd1074));
        end
        else
        begin
            res = signed_sat(d[63], scale_shift({1'b1, frac}, 11'd1075 - e));
        end
        return res;
    endfunction

    logic [63:0]        x;
    logic signed [23:0] w24;
    logic signed [31:0] w32;
    logic signed [23:0] w24_adj;
    logic signed [31:0] w32_adj;
    logic signed [15:0] conv;

    assign x       = in_data.sample_bits;
    assign w24     = x[23:0];
    assign w32     = x[31:0];
    // bias negatives so the arithmetic shift truncates toward zero
    assign w24_adj = w24 + (w24[23] ? 24'sd255 : 24'sd0);
    assign w32_adj = w32 + (w32[31] ? 32'sd65535 : 32'sd0);

    always_comb
    begin
        unique case (sample_format)
            FMT_S8:     conv = {8'h00, ~x[7], x[6:0]};
            FMT_S24:    conv = w24_adj[23:8];
            FMT_S32:    conv = w32_adj[31:16];
            FMT_U8:     conv = {8'h00, x[7:0]};
            FMT_U16:    conv = {~x[15], x[14:0]};
            FMT_U24:    conv = {~x[23], x[22:8]};
            FMT_U32:    conv = {~x[31], x[30:16]};
            FMT_FLOAT:  conv = from_float(x[31:0]);
            FMT_DOUBLE: conv = from_double(x);
            default:    conv = x[15:0];
        endcase
    end

    assign in_ready          = !q_full;
    assign q_push            = in_valid && !q_full;
    assign q_data.value      = conv;
    assign q_data.wide       = !((sample_format == FMT_S8) || (sample_format == FMT_U8));
    assign q_data.buffer_end = in_data.buffer_end;

endmodule

### design/ascd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_queue
// Short FIFO of converted samples between front and back.
// ----------------------------------------------------------------------------
module ascd_queue
    import ascd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     nonempty,
    output q_entry_t pop_data
);

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/ascd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_back
// Tracks the frame position, downmixes frames and drives the result register.
// ----------------------------------------------------------------------------
module ascd_back
    import ascd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] channel_count,
    input  logic       q_nonempty,
    input  q_entry_t   q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    // a / n2 truncated toward zero, n2 = 4, 6 or 8 from the channel count
    function automatic logic [15:0] side_avg(input logic signed [ACC_W-1:0] a,
                                             input logic [3:0] c);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-2:0] half;
        logic [35:0]      prod;
        logic [ACC_W-1:0] q;
        mag  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        half = mag[ACC_W-1:1];
        prod = {18'd0, half} * 36'd87382;
        if (c <= 4'd4)
        begin
            q = mag >> 2;
        end
        else if (c <= 4'd6)
        begin
            q = ACC_W'(prod[35:18]);
        end
        else
        begin
            q = mag >> 3;
        end
        return a[ACC_W-1] ? 16'(-q) : q[15:0];
    endfunction

    logic [3:0]              c_eff;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [ACC_W-1:0] lacc_reg, lacc_next;
    logic signed [ACC_W-1:0] racc_reg, racc_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [15:0]             pend_q_reg, pend_q_next;
    logic                    pend_wide_reg, pend_wide_next;

    logic                    slot_free;
    logic                    pos_first;
    logic                    center;
    logic                    frame_done;
    logic signed [ACC_W-1:0] v_ext;
    logic signed [ACC_W-1:0] v_dbl;
    logic signed [ACC_W-1:0] lnew;
    logic signed [ACC_W-1:0] rnew;

    always_comb
    begin
        priority if (channel_count == 4'd0)
        begin
            c_eff = 4'd1;
        end
        else if (channel_count > MAX_CH)
        begin
            c_eff = MAX_CH;
        end
        else
        begin
            c_eff = channel_count;
        end
    end

    assign slot_free  = !out_valid_reg || out_ready;
    assign q_pop      = slot_free && !pend_valid_reg && q_nonempty;
    assign pos_first  = (pos_reg == '0);
    assign center     = c_eff[0] && pos_first;
    assign frame_done = ({1'b0, pos_reg} + 4'd1) >= c_eff;
    assign v_ext      = ACC_W'(q_data.value);
    assign v_dbl      = v_ext <<< 1;
    assign lnew       = (pos_first ? '0 : lacc_reg)
                      + (center ? v_ext : (!pos_reg[0] ? v_dbl : '0));
    assign rnew       = (pos_first ? '0 : racc_reg)
                      + (center ? v_ext : (pos_reg[0] ? v_dbl : '0));

    always_comb
    begin
        pos_next        = pos_reg;
        lacc_next       = lacc_reg;
        racc_next       = racc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_q_next     = pend_q_reg;
        pend_wide_next  = pend_wide_reg;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_valid_next            = 1'b1;
                out_data_next.out_sample  = pend_q_reg;
                out_data_next.out_wide    = pend_wide_reg;
                out_data_next.out_channel = 1'b1;
                out_data_next.last        = 1'b1;
                pend_valid_next           = 1'b0;
            end
            else if (q_nonempty)
            begin
                out_data_next.out_wide = q_data.wide;
                if (c_eff == 4'd1)
                begin
                    pos_next                  = '0;
                    out_valid_next            = 1'b1;
                    out_data_next.out_sample  = q_data.value;
                    out_data_next.out_channel = 1'b0;
                    out_data_next.last        = 1'b1;
                end
                else if (c_eff == 4'd2)
                begin
                    pos_next                  = (!pos_first || q_data.buffer_end) ? '0 : POS_W'(1);
                    out_valid_next            = 1'b1;
                    out_data_next.out_sample  = q_data.value;
                    out_data_next.out_channel = !pos_first;
                    out_data_next.last        = 1'b1;
                end
                else if (frame_done)
                begin
                    // emit left now, hold right for the next transfer
                    pos_next                  = '0;
                    lacc_next                 = '0;
                    racc_next                 = '0;
                    out_valid_next            = 1'b1;
                    out_data_next.out_sample  = side_avg(lnew, c_eff);
                    out_data_next.out_channel = 1'b0;
                    out_data_next.last        = 1'b0;
                    pend_valid_next           = 1'b1;
                    pend_q_next               = side_avg(rnew, c_eff);
                    pend_wide_next            = q_data.wide;
                end
                else if (q_data.buffer_end)
                begin
                    // drop the partial frame
                    pos_next  = '0;
                    lacc_next = '0;
                    racc_next = '0;
                end
                else
                begin
                    pos_next  = pos_reg + 1'b1;
                    lacc_next = lnew;
                    racc_next = rnew;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        pend_q_reg    <= pend_q_next;
        pend_wide_reg <= pend_wide_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            lacc_reg       <= '0;
            racc_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            lacc_reg       <= lacc_next;
            racc_reg       <= racc_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
